// File: hw/rtl/rpa_pkg.sv
package rpa_pkg;

   // field widths of the request and response words
   localparam int KIND_W   = 2;
   localparam int PAGE_W   = 15;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHARE   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

endpackage

// File: hw/rtl/refcounted_page_allocator.sv
// Page allocator with a share count per page.
// Request channel (req_*, valid/ready): one word per operation, req_kind selects
// allocate, release or share, req_page names the page for release and share.
// Response channel (rsp_*, valid/ready): exactly one word per request, with
// status, the page, its count after the operation and the returned flag.
// Config: csr_we/csr_wdata set the first usable page; write only while idle.
// An accepted request enters the execute state; its response is registered
// in the output register once that is free. The count and stack RAMs are read
// at the accept edge and written back as execute ends, one item in flight.
// A finished response sits in an output register, so the next request is
// taken while it waits; if the receiver stalls longer, the item behind it
// holds in its execute cycle until the output register frees up.
// Reset: synchronous. Afterwards the count RAM is swept to "untouched", one
// entry per cycle, with req_ready low until it ends; csr writes still land.
// Untouched pages read as count 0 inside the free range, 1 otherwise.
module refcounted_page_allocator #(
   parameter int unsigned NUM_PAGES = 32768,
   parameter int unsigned COUNT_MAX = 255
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rpa_pkg::PAGE_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rpa_pkg::KIND_W-1:0]     req_kind,
   input  logic [rpa_pkg::PAGE_W-1:0]     req_page,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rpa_pkg::PAGE_W-1:0]     rsp_page_out,
   output logic [rpa_pkg::COUNT_W-1:0]    rsp_count_after,
   output logic                           rsp_returned
);
   import rpa_pkg::*;

   localparam int AW = $clog2(NUM_PAGES);           // RAM address
   localparam int DW = AW + 1;                      // stack depth, fresh top
   localparam int XW = (DW > PAGE_W) ? DW : PAGE_W; // compare width
   localparam int CW = $clog2(COUNT_MAX + 1);       // share count
   localparam int EW = CW + 1;                      // {touched, count}

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EXEC = 1'b1;

   // control state
   logic          state_ff, state_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [DW-1:0] top_ff, top_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0] fup_ff;

   // request and response words
   logic [KIND_W-1:0]   kind_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PAGE_W-1:0]   pout_ff, pout_in;
   logic [COUNT_W-1:0]  cnt_ff;
   logic                ret_ff, ret_in;

   logic          clr_busy;
   logic [AW-1:0] clr_addr;
   logic          accept;
   logic          go;
   logic [XW-1:0] req_x;

   // RAM ports
   logic          cnt_we;
   logic [AW-1:0] cnt_waddr;
   logic [EW-1:0] cnt_wdata;
   logic [EW-1:0] cnt_rd;
   logic [AW-1:0] stk_rd;

   // execute stage
   logic [XW-1:0] page_x, fup_x, top_x;
   logic          oor, below;
   logic [CW-1:0] cur, cnt_in, dec;
   logic [AW-1:0] alloc_page;
   logic          ex_we, push, pop, take_fresh;
   logic [AW-1:0] ex_addr;
   logic [CW-1:0] ex_cnt;

   rpa_clear #(.DEPTH(NUM_PAGES)) u_clear (
      .clock (clock),
      .reset (reset),
      .busy  (clr_busy),
      .addr  (clr_addr)
   );

   assign req_ready = (state_ff == STATE_IDLE) && !clr_busy;
   assign accept    = req_valid && req_ready;
   assign req_x     = XW'(req_page);

   // result register free or draining this cycle
   assign go = (state_ff == STATE_EXEC) && (!rsp_valid_ff || rsp_ready);

   // the sweep owns the count RAM write port until it finishes
   assign cnt_we    = clr_busy || (go && ex_we);
   assign cnt_waddr = clr_busy ? clr_addr : ex_addr;
   assign cnt_wdata = clr_busy ? '0 : {1'b1, ex_cnt};

   rpa_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (accept),
      .rd_addr (req_x[AW-1:0]),
      .rd_data (cnt_rd)
   );

   // top of stack is fetched on every accept; only allocate uses it
   rpa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (go && push),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (page_x[AW-1:0]),
      .rd_en   (accept),
      .rd_addr (AW'(depth_ff - DW'(1))),
      .rd_data (stk_rd)
   );

   assign page_x = XW'(page_ff);
   assign fup_x  = XW'(fup_ff);
   assign top_x  = XW'(top_ff);
   assign oor    = page_x >= XW'(NUM_PAGES);
   assign below  = page_x < fup_x;
   assign dec    = cur - CW'(1);

   // never-written entry: free (count 0) inside [fup, top), else the reset 1
   assign cur = cnt_rd[CW] ? cnt_rd[CW-1:0] :
                ((!below && (page_x < top_x)) ? '0 : CW'(1));

   // stack first, then the highest untouched page
   assign alloc_page = (depth_ff != '0) ? stk_rd : AW'(top_ff - DW'(1));

   always_comb begin
      status_in  = ST_OK;
      pout_in    = page_ff;
      cnt_in     = cur;
      ret_in     = 1'b0;
      ex_we      = 1'b0;
      ex_addr    = page_x[AW-1:0];
      ex_cnt     = cur;
      push       = 1'b0;
      pop        = 1'b0;
      take_fresh = 1'b0;
      unique case (kind_ff)
         KIND_ALLOC: begin
            if (depth_ff != '0 || (top_x > fup_x && top_ff != '0)) begin
               pop        = (depth_ff != '0);
               take_fresh = (depth_ff == '0);
               ex_we      = 1'b1;
               ex_addr    = alloc_page;
               ex_cnt     = CW'(1);
               pout_in    = PAGE_W'(alloc_page);
               cnt_in     = CW'(1);
            end else begin
               status_in = ST_EMPTY;
               pout_in   = '0;
               cnt_in    = '0;
            end
         end
         KIND_RELEASE: begin
            if (oor) begin
               status_in = ST_RANGE;
               cnt_in    = '0;
            end else if (below) begin
               status_in = ST_RANGE;
            end else if (cur == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               ex_we  = 1'b1;
               ex_cnt = dec;
               cnt_in = dec;
               // a full stack drops the push but keeps the count at zero
               if (dec == '0 && depth_ff < DW'(NUM_PAGES)) begin
                  push   = 1'b1;
                  ret_in = 1'b1;
               end
            end
         end
         KIND_SHARE: begin
            if (oor) begin
               status_in = ST_RANGE;
               cnt_in    = '0;
            end else if (cur >= CW'(COUNT_MAX)) begin
               status_in = ST_OVERFLOW;
               ex_we     = 1'b1;
               ex_cnt    = CW'(COUNT_MAX);
               cnt_in    = CW'(COUNT_MAX);
            end else begin
               ex_we  = 1'b1;
               ex_cnt = cur + CW'(1);
               cnt_in = cur + CW'(1);
            end
         end
         default: begin
            // unknown op: report only
            if (oor) begin
               cnt_in = '0;
            end
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         state_in = STATE_EXEC;
      end
      if (go) begin
         state_in     = STATE_IDLE;
         rsp_valid_in = 1'b1;
         if (pop) begin
            depth_in = depth_ff - DW'(1);
         end else if (push) begin
            depth_in = depth_ff + DW'(1);
         end
         if (take_fresh) begin
            top_in = top_ff - DW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         depth_ff     <= '0;
         top_ff       <= DW'(NUM_PAGES);
         rsp_valid_ff <= 1'b0;
         fup_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            fup_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         page_ff <= req_page;
      end
      if (go) begin
         status_ff <= status_in;
         pout_ff   <= pout_in;
         cnt_ff    <= COUNT_W'(cnt_in);
         ret_ff    <= ret_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_page_out    = pout_ff;
   assign rsp_count_after = cnt_ff;
   assign rsp_returned    = ret_ff;

endmodule

// File: hw/rtl/rpa_ram.sv
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rpa_clear.sv
module rpa_clear #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     busy,
   output logic [$clog2(DEPTH)-1:0] addr
);

   localparam int AW = $clog2(DEPTH);

   logic          busy_ff, busy_in;
   logic [AW-1:0] addr_ff, addr_in;

   // one entry per cycle, starting right after reset
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + AW'(1);
         if (addr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign busy = busy_ff;
   assign addr = addr_ff;

endmodule

// File: hw/rtl/rpa_checker.sv
module rpa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rpa_pkg::STATUS_W-1:0] rsp_status,
   input logic [rpa_pkg::PAGE_W-1:0]   rsp_page_out,
   input logic [rpa_pkg::COUNT_W-1:0]  rsp_count_after,
   input logic                         rsp_returned
);
   import rpa_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_page_out) && $stable(rsp_count_after) && $stable(rsp_returned))
      else $error("response word changed under stall");

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during execute");

   // a page pushed back to the pool has count zero and ok status
   a_returned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_returned |-> rsp_status == ST_OK && rsp_count_after == '0)
      else $error("returned page with nonzero count or error");

   // empty pool and underflow report no page count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_UNDERFLOW) |->
      rsp_count_after == '0 && !rsp_returned)
      else $error("error response carries a count");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_page_out    (rsp_page_out),
   .rsp_count_after (rsp_count_after),
   .rsp_returned    (rsp_returned)
);
